@@ rtl/core/wsd_pkg.sv @@
// Shared types for the WebSocket frame deframer: parser phases, result kinds
// and the result record passed from the parser to the output register.
// No dependencies.
`default_nettype none

package wsd_pkg;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_LEN     = 3'd1,
        PH_EXT_HI  = 3'd2,
        PH_EXT_LO  = 3'd3,
        PH_MASK    = 3'd4,
        PH_PAYLOAD = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_ERROR  = 2'd2
    } t_kind;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    typedef struct packed {
        t_kind       kind;
        logic [6:0]  frame_opcode;
        logic [15:0] payload_length;
        logic        was_masked;
        logic [7:0]  data_byte;
        logic        last;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/core/wsd_parser.sv @@
// Frame header parser and payload unmasker for the deframer.
// Holds the frame state and forms at most one result per byte; uses wsd_pkg.
`default_nettype none

module wsd_parser (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire logic [7:0]       i_byte,
    output logic                  o_res_valid,
    output wsd_pkg::t_result      o_res
);
    import wsd_pkg::*;

    t_phase      r_phase, n_phase;
    logic [6:0]  r_opcode, n_opcode;
    logic [15:0] r_length, n_length;
    logic        r_mask_flag, n_mask_flag;
    logic [31:0] r_mask_key, n_mask_key;
    logic [1:0]  r_sub_count, n_sub_count;
    logic [15:0] r_payload_index, n_payload_index;

    logic        v_after_len;
    logic        v_header;
    logic [15:0] v_hdr_len;
    logic [7:0]  v_key;
    logic        v_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_opcode        <= '0;
            r_length        <= '0;
            r_mask_flag     <= 1'b0;
            r_mask_key      <= '0;
            r_sub_count     <= '0;
            r_payload_index <= '0;
        end else if (i_step) begin
            r_phase         <= n_phase;
            r_opcode        <= n_opcode;
            r_length        <= n_length;
            r_mask_flag     <= n_mask_flag;
            r_mask_key      <= n_mask_key;
            r_sub_count     <= n_sub_count;
            r_payload_index <= n_payload_index;
        end
    end

    always_comb begin
        case (r_payload_index[1:0])
            2'd0:    v_key = r_mask_key[7:0];
            2'd1:    v_key = r_mask_key[15:8];
            2'd2:    v_key = r_mask_key[23:16];
            default: v_key = r_mask_key[31:24];
        endcase
        v_fin = ({1'b0, r_payload_index} + 17'd1) >= {1'b0, r_length};
    end

    always_comb begin
        n_phase         = r_phase;
        n_opcode        = r_opcode;
        n_length        = r_length;
        n_mask_flag     = r_mask_flag;
        n_mask_key      = r_mask_key;
        n_sub_count     = r_sub_count;
        n_payload_index = r_payload_index;
        v_after_len     = 1'b0;
        v_header        = 1'b0;
        v_hdr_len       = r_length;
        o_res_valid     = 1'b0;
        o_res           = '0;
        o_res.frame_opcode = r_opcode;

        case (r_phase)
            PH_LEN: begin
                n_mask_flag = i_byte[7];
                if (i_byte[6:0] == LEN7_EXT64) begin
                    o_res_valid         = 1'b1;
                    o_res.kind          = KIND_ERROR;
                    o_res.last          = 1'b1;
                    n_phase             = PH_IDLE;
                end else if (i_byte[6:0] == LEN7_EXT16) begin
                    n_phase = PH_EXT_HI;
                end else begin
                    n_length    = {9'd0, i_byte[6:0]};
                    v_after_len = 1'b1;
                end
            end
            PH_EXT_HI: begin
                n_length = {i_byte, 8'd0};
                n_phase  = PH_EXT_LO;
            end
            PH_EXT_LO: begin
                n_length    = {r_length[15:8], i_byte};
                v_after_len = 1'b1;
            end
            PH_MASK: begin
                case (r_sub_count)
                    2'd0:    n_mask_key[7:0]   = i_byte;
                    2'd1:    n_mask_key[15:8]  = i_byte;
                    2'd2:    n_mask_key[23:16] = i_byte;
                    default: n_mask_key[31:24] = i_byte;
                endcase
                if (r_sub_count == 2'd3) begin
                    n_sub_count = 2'd0;
                    v_header    = 1'b1;
                end else begin
                    n_sub_count = r_sub_count + 2'd1;
                end
            end
            PH_PAYLOAD: begin
                o_res_valid          = 1'b1;
                o_res.kind           = KIND_DATA;
                o_res.payload_length = r_length;
                o_res.data_byte      = r_mask_flag ? (i_byte ^ v_key) : i_byte;
                o_res.last           = v_fin;
                if (v_fin) begin
                    n_phase         = PH_IDLE;
                    n_payload_index = '0;
                end else begin
                    n_payload_index = r_payload_index + 16'd1;
                end
            end
            default: begin
                // unused phase codes behave as idle: start a new frame
                n_opcode    = i_byte[6:0];
                n_mask_flag = 1'b0;
                n_length    = '0;
                n_phase     = PH_LEN;
            end
        endcase

        // masked frames collect the key before the header is reported
        if (v_after_len) begin
            if (n_mask_flag) begin
                n_sub_count = 2'd0;
                n_phase     = PH_MASK;
            end else begin
                v_header = 1'b1;
            end
        end

        if (v_header) begin
            v_hdr_len            = n_length;
            o_res_valid          = 1'b1;
            o_res.kind           = KIND_HEADER;
            o_res.payload_length = v_hdr_len;
            o_res.last           = (v_hdr_len == 16'd0);
            n_payload_index      = '0;
            n_phase              = (v_hdr_len == 16'd0) ? PH_IDLE : PH_PAYLOAD;
        end

        o_res.was_masked = n_mask_flag;
    end

`ifndef SYNTHESIS
    a_sub_count_in_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sub_count != 2'd0) |-> (r_phase == PH_MASK))
        else $error("key byte count nonzero outside key phase");

    a_data_only_in_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res_valid && o_res.kind == KIND_DATA) |-> (r_phase == PH_PAYLOAD))
        else $error("payload result outside payload phase");

    a_last_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res_valid && o_res.last) |=> (r_phase == PH_IDLE))
        else $error("final result did not return parser to idle");

    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res_valid && o_res.kind == KIND_ERROR)
            |-> (o_res.last && o_res.payload_length == 16'd0))
        else $error("error result malformed");
`endif

endmodule

`default_nettype wire

@@ rtl/core/websocket_frame_deframer_top.sv @@
// WebSocket frame deframer: one byte per cycle while results are taken; each byte is held in
// the input register, and its result then in the result register.
// Throughput is one byte per cycle; a held result that is not taken stalls the input.
// A result comes from each payload byte and from the byte that ends a header or errs.
// Synchronous active-low reset returns the parser to idle at once.
// Instantiates wsd_parser; uses wsd_pkg.
`default_nettype none

module websocket_frame_deframer_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_rx_valid,
    output logic             o_rx_ready,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_res_valid,
    input  wire logic        i_res_ready,
    output logic [1:0]       o_kind,
    output logic [6:0]       o_frame_opcode,
    output logic [15:0]      o_payload_length,
    output logic             o_was_masked,
    output logic [7:0]       o_data_byte,
    output logic             o_last
);
    import wsd_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;

    logic       advance;
    logic       res_valid;
    t_result    res;

    // advance the held request once the result slot is free or draining
    assign advance    = r_in_valid && (!r_out_valid || i_res_ready);
    assign o_rx_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_rx_ready) begin
            r_in_valid <= i_rx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rx_ready && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    wsd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_byte      (r_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= res_valid;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    assign o_res_valid      = r_out_valid;
    assign o_kind           = r_out.kind;
    assign o_frame_opcode   = r_out.frame_opcode;
    assign o_payload_length = r_out.payload_length;
    assign o_was_masked     = r_out.was_masked;
    assign o_data_byte      = r_out.data_byte;
    assign o_last           = r_out.last;

endmodule

`default_nettype wire
